>>> rtl/assert_macros.svh
// assertion helpers for the gate engine checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the cycle after the antecedent, outside reset
`define SQG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sqg checker: next-cycle property failed");

// consequent must hold in the cycle after reset was seen
`define SQG_ASSERT_AFTER_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("sqg checker: post-reset property failed");

`endif

>>> rtl/sqg_pkg.sv
package sqg_pkg;

  // event codes
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_ON   = 2'd1;
  localparam logic [1:0] EV_OFF  = 2'd2;

  // gate modes
  localparam logic [1:0] GATE_HOLD      = 2'd0;
  localparam logic [1:0] GATE_ONCE      = 2'd1;
  localparam logic [1:0] GATE_ONCE_HOLD = 2'd2;
  localparam logic [1:0] GATE_REPEAT    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_STEP_COUNT  = 2'd0;
  localparam logic [1:0] REG_STEP_OFFSET = 2'd1;
  localparam logic [1:0] REG_PERIOD      = 2'd2;
  localparam logic [1:0] REG_GATE_LEN    = 2'd3;

  localparam logic [4:0]  RST_STEP_COUNT  = 5'd16;
  localparam logic [4:0]  RST_STEP_OFFSET = 5'd1;
  localparam logic [15:0] RST_PERIOD      = 16'd1000;
  localparam logic [15:0] RST_GATE_LEN    = 16'd500;

  typedef struct packed {
    logic [7:0] reps;
    logic [1:0] gate;
    logic [6:0] note;
  } entry_t;

  typedef struct packed {
    logic [4:0]        step_count;
    logic signed [4:0] step_offset;
    logic [15:0]       period;
    logic [15:0]       gate_len;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic mem_write;
    logic time_add;
    logic gate_run;
    logic wrap_run;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic do_step;
    logic wrap_done;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/sqg_in_if.sv
interface sqg_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] elapsed;
  logic [3:0]  entry_index;
  logic [6:0]  entry_note;
  logic [1:0]  entry_gate;
  logic [7:0]  entry_repeats;

  modport source (
    output valid, operation, elapsed, entry_index, entry_note, entry_gate, entry_repeats,
    input  ready
  );
  modport sink (
    input  valid, operation, elapsed, entry_index, entry_note, entry_gate, entry_repeats,
    output ready
  );
endinterface

>>> rtl/sqg_out_if.sv
interface sqg_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [6:0] event_note;
  logic [3:0] current_step;
  logic [7:0] current_repeat;

  modport source (
    output valid, event_res, event_note, current_step, current_repeat,
    input  ready
  );
  modport sink (
    input  valid, event_res, event_note, current_step, current_repeat,
    output ready
  );
endinterface

>>> rtl/sqg_ctrl.sv
module sqg_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_write,
  input  sqg_pkg::sts_t sts,
  output logic          ready,
  output sqg_pkg::cmd_t cmd
);
  import sqg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_TIME,
    S_GATE,
    S_WRAP,
    S_SETTLE,
    S_DONE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= in_write ? S_WRITE : S_TIME;
        end
        S_WRITE:  state <= S_SETTLE;
        S_TIME:   state <= S_GATE;
        S_GATE:   state <= sts.do_step ? S_WRAP : S_SETTLE;
        S_WRAP: begin
          if (sts.wrap_done) state <= S_SETTLE;
        end
        S_SETTLE: state <= S_DONE;
        S_DONE: begin
          if (sts.out_free) state <= S_IDLE;
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    ready         = (state == S_IDLE);
    cmd.accept    = (state == S_IDLE) && in_valid;
    cmd.mem_write = (state == S_WRITE);
    cmd.time_add  = (state == S_TIME);
    cmd.gate_run  = (state == S_GATE);
    cmd.wrap_run  = (state == S_WRAP);
    cmd.out_load  = (state == S_DONE) && sts.out_free;
  end

endmodule

>>> rtl/sqg_dp.sv
module sqg_dp #(
  parameter int MAX_STEPS = 16,
  parameter int TIME_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  sqg_pkg::cmd_t cmd,
  input  sqg_pkg::cfg_t cfg,
  output sqg_pkg::sts_t sts,
  input  logic [15:0]   in_elapsed,
  input  logic [3:0]    in_index,
  input  logic [6:0]    in_note,
  input  logic [1:0]    in_gate,
  input  logic [7:0]    in_repeats,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [1:0]    out_event,
  output logic [6:0]    out_note,
  output logic [3:0]    out_step,
  output logic [7:0]    out_repeat
);
  import sqg_pkg::*;

  localparam int PW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int WW = PW + 6;
  localparam int CW = (TIME_BITS > 16) ? TIME_BITS : 16;
  localparam int SW = CW + 1;
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

  typedef enum logic [2:0] {
    PH_INITIAL,
    PH_HOLD_ON,
    PH_ONCE_ON,
    PH_HOLD_OFF,
    PH_OTH_ON,
    PH_OTH_OFF,
    PH_REP_ON,
    PH_REP_OFF
  } phase_t;

  entry_t                step_mem [MAX_STEPS];
  entry_t                rd_ent;
  entry_t                ent_q;
  logic [3:0]            idx_q;
  logic [15:0]           elapsed_q;
  logic [TIME_BITS-1:0]  time_count;
  phase_t                gate_phase;
  logic [PW-1:0]         step_position;
  logic [7:0]            repeat_count;
  logic [1:0]            ev_q;
  logic signed [WW-1:0]  wrap_val;
  logic signed [WW-1:0]  wrap_n;

  logic [SW-1:0]         time_sum;
  logic                  next_cyc;
  logic                  gate_pass;
  logic                  reps_done;
  logic                  idx_ok;
  logic                  wrap_done;
  logic signed [WW-1:0]  n_eff;
  phase_t                phase_next;
  logic [1:0]            ev_next;
  logic                  clr_time;
  logic                  next_rep;
  logic                  do_step;

  assign time_sum  = SW'(time_count) + SW'(elapsed_q);
  assign next_cyc  = CW'(time_count) >= CW'(cfg.period);
  assign gate_pass = CW'(time_count) >= CW'(cfg.gate_len);
  assign reps_done = repeat_count >= rd_ent.reps;
  assign idx_ok    = 32'(idx_q) < 32'(MAX_STEPS);
  assign wrap_done = !wrap_val[WW-1] && (wrap_val < wrap_n);

  // step count clamped to the table size, zero acts as one
  always_comb begin
    if (cfg.step_count == 5'd0) begin
      n_eff = WW'(1);
    end else if (WW'(cfg.step_count) > WW'(MAX_STEPS)) begin
      n_eff = $signed(WW'(MAX_STEPS));
    end else begin
      n_eff = $signed(WW'(cfg.step_count));
    end
  end

  always_comb begin
    phase_next = gate_phase;
    ev_next    = EV_NONE;
    clr_time   = 1'b0;
    next_rep   = 1'b0;
    do_step    = 1'b0;
    case (gate_phase)
      PH_INITIAL: begin
        if (next_cyc) begin
          clr_time = 1'b1;
          ev_next  = EV_ON;
          case (rd_ent.gate)
            GATE_HOLD:      phase_next = PH_HOLD_ON;
            GATE_ONCE:      phase_next = PH_ONCE_ON;
            GATE_ONCE_HOLD: phase_next = PH_OTH_ON;
            default:        phase_next = PH_REP_ON;
          endcase
        end
      end
      PH_HOLD_ON: begin
        if (gate_pass && reps_done) begin
          ev_next    = EV_OFF;
          do_step    = 1'b1;
          phase_next = PH_INITIAL;
        end else if (next_cyc) begin
          next_rep = 1'b1;
        end
      end
      PH_ONCE_ON: begin
        if (gate_pass) begin
          ev_next    = EV_OFF;
          phase_next = PH_HOLD_OFF;
        end
      end
      PH_HOLD_OFF: begin
        if (next_cyc) begin
          if (reps_done) begin
            do_step    = 1'b1;
            phase_next = PH_INITIAL;
          end else begin
            next_rep = 1'b1;
          end
        end
      end
      PH_OTH_ON: begin
        if (gate_pass) begin
          ev_next    = EV_OFF;
          phase_next = PH_OTH_OFF;
        end
      end
      PH_OTH_OFF: begin
        if (next_cyc) begin
          if (!reps_done) begin
            ev_next    = EV_ON;
            next_rep   = 1'b1;
            phase_next = PH_HOLD_ON;
          end else begin
            do_step    = 1'b1;
            phase_next = PH_INITIAL;
          end
        end
      end
      PH_REP_ON: begin
        if (gate_pass) begin
          ev_next    = EV_OFF;
          phase_next = PH_REP_OFF;
        end
      end
      default: begin
        if (next_cyc) begin
          if (reps_done) begin
            do_step    = 1'b1;
            phase_next = PH_INITIAL;
          end else begin
            next_rep   = 1'b1;
            ev_next    = EV_ON;
            phase_next = PH_REP_ON;
          end
        end
      end
    endcase
  end

  // step table, read data is registered and follows the step position in the next cycle
  always_ff @(posedge clk) begin
    if (cmd.mem_write && idx_ok) step_mem[PW'(idx_q)] <= ent_q;
    rd_ent <= step_mem[step_position];
  end

  // item capture and wrap working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_q     <= in_index;
      elapsed_q <= in_elapsed;
      ent_q     <= '{reps: in_repeats, gate: in_gate, note: in_note};
    end
    if (cmd.gate_run && do_step) begin
      wrap_val <= $signed(WW'(step_position)) + WW'($signed(cfg.step_offset));
      wrap_n   <= n_eff;
    end else if (cmd.wrap_run && !wrap_done) begin
      if (wrap_val[WW-1]) wrap_val <= wrap_val + wrap_n;
      else wrap_val <= wrap_val - wrap_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_phase    <= PH_INITIAL;
      step_position <= '0;
      repeat_count  <= '0;
      time_count    <= '0;
      ev_q          <= EV_NONE;
    end else begin
      if (cmd.accept) ev_q <= EV_NONE;
      if (cmd.time_add) begin
        time_count <= (time_sum > SW'(TMAX)) ? TMAX : time_sum[TIME_BITS-1:0];
      end
      if (cmd.gate_run) begin
        gate_phase <= phase_next;
        ev_q       <= ev_next;
        if (clr_time || next_rep) time_count <= '0;
        if (next_rep && repeat_count != 8'hff) repeat_count <= repeat_count + 8'd1;
        if (do_step) repeat_count <= '0;
      end
      if (cmd.wrap_run && wrap_done) step_position <= wrap_val[PW-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_event  <= ev_q;
      out_note   <= rd_ent.note;
      out_step   <= 4'(step_position);
      out_repeat <= repeat_count;
    end
  end

  assign sts.do_step   = do_step;
  assign sts.wrap_done = wrap_done;
  assign sts.out_free  = !out_valid || out_ready;

endmodule

>>> rtl/step_sequencer_gate_engine_top.sv
// sequence: a write item goes through the write, settle and done states before its result is
//   registered; a tick goes through time, gate, wrap (k add/subtract rounds, only when a step
//   finishes, up to 30 rounds with count one, position and offset 15), settle and done
// flow: one item at a time; a new item waits until the last result is loaded past any stall
// reset: synchronous, active high; clears gate phase, step, repeat, time and config registers
//   to defaults; the step table is not cleared and must be written before it is played
module step_sequencer_gate_engine_top #(
  parameter int MAX_STEPS = 16,
  parameter int TIME_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  sqg_in_if.sink       item_in,
  sqg_out_if.source    result_out,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import sqg_pkg::*;

  cfg_t       cfg;
  cmd_t       cmd;
  sts_t       sts;
  logic [1:0] reg_sel;
  logic       reg_wr;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_count  <= RST_STEP_COUNT;
      cfg.step_offset <= $signed(RST_STEP_OFFSET);
      cfg.period      <= RST_PERIOD;
      cfg.gate_len    <= RST_GATE_LEN;
    end else if (reg_wr) begin
      case (reg_sel)
        REG_STEP_COUNT:  cfg.step_count  <= pwdata[4:0];
        REG_STEP_OFFSET: cfg.step_offset <= $signed(pwdata[4:0]);
        REG_PERIOD:      cfg.period      <= pwdata[15:0];
        REG_GATE_LEN:    cfg.gate_len    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_STEP_COUNT:  prdata = {27'd0, cfg.step_count};
      REG_STEP_OFFSET: prdata = {27'd0, cfg.step_offset};
      REG_PERIOD:      prdata = {16'd0, cfg.period};
      REG_GATE_LEN:    prdata = {16'd0, cfg.gate_len};
      default:         prdata = '0;
    endcase
  end

  sqg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_in.valid),
    .in_write (item_in.operation),
    .sts      (sts),
    .ready    (item_in.ready),
    .cmd      (cmd)
  );

  sqg_dp #(
    .MAX_STEPS (MAX_STEPS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg        (cfg),
    .sts        (sts),
    .in_elapsed (item_in.elapsed),
    .in_index   (item_in.entry_index),
    .in_note    (item_in.entry_note),
    .in_gate    (item_in.entry_gate),
    .in_repeats (item_in.entry_repeats),
    .out_ready  (result_out.ready),
    .out_valid  (result_out.valid),
    .out_event  (result_out.event_res),
    .out_note   (result_out.event_note),
    .out_step   (result_out.current_step),
    .out_repeat (result_out.current_repeat)
  );

endmodule

>>> rtl/sqg_checker.sv
`include "assert_macros.svh"

module sqg_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] event_res,
  input logic [6:0] event_note,
  input logic [3:0] current_step,
  input logic [7:0] current_repeat
);

  logic [20:0] out_bits;

  assign out_bits = {event_res, event_note, current_step, current_repeat};

  // one item in flight: the engine is busy right after taking an item
  `SQG_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // no result appears straight out of reset
  `SQG_ASSERT_AFTER_RESET(a_no_result_after_reset, !out_valid)

  // a stalled result stays offered and unchanged
  `SQG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `SQG_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_bits))

endmodule

bind step_sequencer_gate_engine_top sqg_checker u_sqg_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (item_in.valid),
  .in_ready       (item_in.ready),
  .out_valid      (result_out.valid),
  .out_ready      (result_out.ready),
  .event_res      (result_out.event_res),
  .event_note     (result_out.event_note),
  .current_step   (result_out.current_step),
  .current_repeat (result_out.current_repeat)
);
